// ===== sv/isc_pkg.sv =====
// isc_pkg: shared constants, types and the power-level helper for the init-script patcher
// used by isc_patch, init_script_command_patcher and isc_checker; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package isc_pkg;

   localparam int POWER_LEVELS = 16;

   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 9;
   localparam int OPC_W   = 16;
   localparam int COUNT_W = 24;
   localparam int PKT_W   = 16;
   localparam int DB_W    = 7;
   localparam int PWR_W   = 9;
   localparam int CSR_W   = 24;
   localparam int CSR_IDX_W = 2;

   localparam logic [OPC_W-1:0] OPC_POWER_VECTOR = 16'hFD82;
   localparam logic [OPC_W-1:0] OPC_POWER_LEVEL  = 16'hFD87;
   localparam logic [OPC_W-1:0] OPC_SLEEP_CFG    = 16'hFD0C;

   localparam logic [BYTE_W-1:0] PKT_TYPE_CMD = 8'd1;

   localparam logic signed [PWR_W-1:0] DB_FLOOR       = -9'sd35;
   localparam logic signed [PWR_W-1:0] DB_STEP        = 9'sd5;
   localparam logic signed [PWR_W-1:0] LEVEL_LIMIT_DB = 9'sd4;
   localparam logic signed [PWR_W-1:0] DB_START_GFSK  = 9'sd12;
   localparam logic signed [PWR_W-1:0] DB_START_EDR   = 9'sd10;
   localparam logic [2:0] MAX_STEPS = 3'd6;

   localparam logic [COUNT_W-1:0] BYTES_MAX = 24'hFFFFFF;

   // run status codes
   localparam logic [1:0] ST_RUNNING  = 2'd0;
   localparam logic [1:0] ST_DONE     = 2'd1;
   localparam logic [1:0] ST_BAD_TYPE = 2'd2;
   localparam logic [1:0] ST_MISMATCH = 2'd3;

   // parser phases
   localparam logic [1:0] PH_TYPE = 2'd0;
   localparam logic [1:0] PH_BODY = 2'd1;
   localparam logic [1:0] PH_IDLE = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_POWER    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLEEP_EN     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCRIPT_SIZE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EXP_PACKETS  = 2'd3;

   localparam logic signed [DB_W-1:0] MAX_POWER_RESET   = 7'sd13;
   localparam logic [COUNT_W-1:0]     SCRIPT_SIZE_RESET = 24'hFFFFFF;
   localparam logic [PKT_W-1:0]       EXP_PACKETS_RESET = 16'd300;

   typedef struct packed {
      logic [OPC_W-1:0]         opcode;
      logic [BYTE_W-1:0]        mod_kind;
      logic signed [DB_W-1:0]   max_power_db;
      logic                     sleep_enable;
   } patch_ctx_type;

   // highest level whose power is below the limit; start values are at most 12 dB,
   // so three steps always settle
   function automatic logic [BYTE_W-1:0] level_below_limit(input logic signed [PWR_W-1:0] p);
      logic signed [PWR_W-1:0] q;
      logic [BYTE_W-1:0]       lvl;
      logic                    hit;
      q   = p;
      lvl = BYTE_W'(POWER_LEVELS - 1);
      hit = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (!hit) begin
            if (q < LEVEL_LIMIT_DB) begin
               hit = 1'b1;
            end else if (lvl != '0) begin
               q   = q - DB_STEP;
               lvl = lvl - 8'd1;
            end
         end
      end
      return lvl;
   endfunction

endpackage

`default_nettype wire

// ===== sv/isc_patch.sv =====
// isc_patch: byte rewrite for the power-vector, power-level and sleep-config commands
// depends on isc_pkg
`timescale 1ns / 1ps
`default_nettype none

module isc_patch (
   input  var isc_pkg::patch_ctx_type       ctx,
   input  logic [isc_pkg::INDEX_W-1:0]      idx,
   input  logic [isc_pkg::BYTE_W-1:0]       byte_raw,
   output logic [isc_pkg::BYTE_W-1:0]       byte_out
);
   import isc_pkg::*;

   logic signed [PWR_W-1:0] max_ext;
   logic signed [PWR_W-1:0] vec_lim;
   logic signed [PWR_W-1:0] lvl_lim;
   logic signed [PWR_W-1:0] vec_raw;
   logic signed [PWR_W-1:0] vec_db;
   logic [INDEX_W-1:0]      steps_left;
   logic [2:0]              steps;
   logic [PWR_W-1:0]        drop;
   logic                    in_vec;
   logic                    in_lvl;

   assign max_ext = PWR_W'(ctx.max_power_db);

   // limited start power for the vector, from the modulation byte
   always_comb begin
      vec_lim = (ctx.mod_kind == '0) ? DB_START_GFSK : DB_START_EDR;
      if (max_ext < vec_lim) vec_lim = max_ext;
   end

   // limited power for the level table, modulation kind is idx - 3
   always_comb begin
      lvl_lim = (idx == INDEX_W'(3)) ? DB_START_GFSK : DB_START_EDR;
      if (max_ext < lvl_lim) lvl_lim = max_ext;
   end

   assign in_vec = (idx >= INDEX_W'(5)) && (idx <= INDEX_W'(POWER_LEVELS + 3));
   assign in_lvl = (idx >= INDEX_W'(3)) && (idx <= INDEX_W'(5));

   assign steps_left = INDEX_W'(POWER_LEVELS + 3) - idx;
   assign steps      = (steps_left > INDEX_W'(MAX_STEPS)) ? MAX_STEPS : steps_left[2:0];
   assign drop       = PWR_W'(steps) * PWR_W'(5);
   assign vec_raw    = vec_lim - signed'(drop);

   always_comb begin
      vec_db = vec_raw;
      if ((steps_left != '0) && (vec_raw < DB_FLOOR)) vec_db = DB_FLOOR;
   end

   always_comb begin
      byte_out = byte_raw;
      case (ctx.opcode)
         OPC_POWER_VECTOR: begin
            if (in_vec) byte_out = {vec_db[BYTE_W-2:0], 1'b0};
         end
         OPC_POWER_LEVEL: begin
            if (in_lvl) byte_out = level_below_limit(lvl_lim);
         end
         OPC_SLEEP_CFG: begin
            if (idx == INDEX_W'(4)) byte_out = {{(BYTE_W-1){1'b0}}, ctx.sleep_enable};
         end
         default: begin
            byte_out = byte_raw;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/init_script_command_patcher.sv =====
// init_script_command_patcher: parses init-script packets, patches command bytes, checks size
// depends on isc_pkg and isc_patch
//
//   channel | ports                                             | direction
//   req     | req_valid, req_ready, req_script_byte            | in
//   rsp     | rsp_valid, rsp_ready, rsp_cmd_byte, rsp_byte_valid, rsp_last_of_cmd, rsp_status | out
//   csr     | csr_write_en, csr_index, csr_wdata                | in, write only
//
// one byte per cycle sustained while rsp is not stalled: an input register, one pass of
// parse and patch logic, and an output register; a byte's result passes both registers onto rsp
// bytes that give no result (type bytes, bytes after done or fail) are still taken from req
// a stalled rsp holds the output register; req keeps flowing while the output is free
// reset clears the parser, the counters and the valid flags and sets the configuration registers to their defaults
`timescale 1ns / 1ps
`default_nettype none

module init_script_command_patcher (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [isc_pkg::BYTE_W-1:0]      req_script_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [isc_pkg::BYTE_W-1:0]      rsp_cmd_byte,
   output logic                            rsp_byte_valid,
   output logic                            rsp_last_of_cmd,
   output logic [1:0]                      rsp_status,
   input  logic                            csr_write_en,
   input  logic [isc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [isc_pkg::CSR_W-1:0]       csr_wdata
);
   import isc_pkg::*;

   // configuration
   logic signed [DB_W-1:0] max_power_ff;
   logic                   sleep_en_ff;
   logic [COUNT_W-1:0]     script_size_ff;
   logic [PKT_W-1:0]       exp_packets_ff;

   // input register
   logic                   in_valid_ff;
   logic [BYTE_W-1:0]      in_byte_ff;

   // parser state
   logic [1:0]             phase_ff, phase_in;
   logic [INDEX_W-1:0]     cmd_index_ff, cmd_index_in;
   logic [OPC_W-1:0]       opcode_ff, opcode_in;
   logic [BYTE_W-1:0]      plen_ff, plen_in;
   logic [BYTE_W-1:0]      mod_kind_ff, mod_kind_in;
   logic [COUNT_W-1:0]     consumed_ff, consumed_in;
   logic [PKT_W-1:0]       packets_ff, packets_in;
   logic [1:0]             status_ff, status_in;

   // output register
   logic                   out_valid_ff;
   logic [BYTE_W-1:0]      out_byte_ff, out_byte_in;
   logic                   out_bvalid_ff, out_bvalid_in;
   logic                   out_last_ff, out_last_in;
   logic [1:0]             out_status_ff;

   logic                   advance;
   logic                   produce;
   logic [COUNT_W-1:0]     consumed_inc;
   logic [INDEX_W-1:0]     last_index;
   logic [BYTE_W-1:0]      plen_eff;
   logic                   is_last;
   logic [BYTE_W-1:0]      patched;
   patch_ctx_type          ctx;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign ctx = {opcode_ff, mod_kind_ff, max_power_ff, sleep_en_ff};

   isc_patch u_patch (
      .ctx      (ctx),
      .idx      (cmd_index_ff),
      .byte_raw (in_byte_ff),
      .byte_out (patched)
   );

   assign consumed_inc = (consumed_ff < BYTES_MAX) ? consumed_ff + 24'd1 : consumed_ff;
   assign plen_eff     = (cmd_index_ff == INDEX_W'(2)) ? in_byte_ff : plen_ff;
   assign last_index   = INDEX_W'(2) + INDEX_W'(plen_eff);
   assign is_last      = (cmd_index_ff >= INDEX_W'(2)) && (cmd_index_ff == last_index);

   always_comb begin
      phase_in      = phase_ff;
      cmd_index_in  = cmd_index_ff;
      opcode_in     = opcode_ff;
      plen_in       = plen_ff;
      mod_kind_in   = mod_kind_ff;
      consumed_in   = consumed_ff;
      packets_in    = packets_ff;
      status_in     = status_ff;
      produce       = 1'b0;
      out_byte_in   = '0;
      out_bvalid_in = 1'b0;
      out_last_in   = 1'b0;
      case (phase_ff)
         PH_TYPE: begin
            if (consumed_ff >= script_size_ff) begin
               status_in = (packets_ff == exp_packets_ff) ? ST_DONE : ST_MISMATCH;
               phase_in  = PH_IDLE;
               produce   = 1'b1;
            end else if (in_byte_ff != PKT_TYPE_CMD) begin
               status_in = ST_BAD_TYPE;
               phase_in  = PH_IDLE;
               produce   = 1'b1;
            end else begin
               consumed_in  = consumed_inc;
               cmd_index_in = '0;
               phase_in     = PH_BODY;
            end
         end
         PH_BODY: begin
            case (cmd_index_ff)
               INDEX_W'(0): opcode_in   = {opcode_ff[OPC_W-1:BYTE_W], in_byte_ff};
               INDEX_W'(1): opcode_in   = {in_byte_ff, opcode_ff[BYTE_W-1:0]};
               INDEX_W'(2): plen_in     = in_byte_ff;
               INDEX_W'(3): mod_kind_in = in_byte_ff;
               default:     opcode_in   = opcode_ff;
            endcase
            consumed_in   = consumed_inc;
            cmd_index_in  = cmd_index_ff + 9'd1;
            produce       = 1'b1;
            out_byte_in   = patched;
            out_bvalid_in = 1'b1;
            out_last_in   = is_last;
            if (is_last) begin
               packets_in = packets_ff + 16'd1;
               phase_in   = PH_TYPE;
               if (consumed_inc >= script_size_ff) begin
                  status_in = (packets_in == exp_packets_ff) ? ST_DONE : ST_MISMATCH;
                  phase_in  = PH_IDLE;
               end
            end
         end
         default: begin
            produce = 1'b0;
         end
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_power_ff   <= MAX_POWER_RESET;
         sleep_en_ff    <= 1'b0;
         script_size_ff <= SCRIPT_SIZE_RESET;
         exp_packets_ff <= EXP_PACKETS_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MAX_POWER:   max_power_ff   <= signed'(csr_wdata[DB_W-1:0]);
            CSR_SLEEP_EN:    sleep_en_ff    <= csr_wdata[0];
            CSR_SCRIPT_SIZE: script_size_ff <= csr_wdata[COUNT_W-1:0];
            CSR_EXP_PACKETS: exp_packets_ff <= csr_wdata[PKT_W-1:0];
            default:         sleep_en_ff    <= sleep_en_ff;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_script_byte;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TYPE;
         cmd_index_ff <= '0;
         opcode_ff    <= '0;
         plen_ff      <= '0;
         mod_kind_ff  <= '0;
         consumed_ff  <= '0;
         packets_ff   <= '0;
         status_ff    <= ST_RUNNING;
      end else if (advance) begin
         phase_ff     <= phase_in;
         cmd_index_ff <= cmd_index_in;
         opcode_ff    <= opcode_in;
         plen_ff      <= plen_in;
         mod_kind_ff  <= mod_kind_in;
         consumed_ff  <= consumed_in;
         packets_ff   <= packets_in;
         status_ff    <= status_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && produce) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && produce) begin
         out_byte_ff   <= out_byte_in;
         out_bvalid_ff <= out_bvalid_in;
         out_last_ff   <= out_last_in;
         out_status_ff <= status_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_cmd_byte    = out_byte_ff;
   assign rsp_byte_valid  = out_bvalid_ff;
   assign rsp_last_of_cmd = out_last_ff;
   assign rsp_status      = out_status_ff;

endmodule

`default_nettype wire

// ===== sv/isc_checker.sv =====
// isc_checker: port-level assertions for init_script_command_patcher, bound to the top level
// depends on isc_pkg
`timescale 1ns / 1ps
`default_nettype none

module isc_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [isc_pkg::BYTE_W-1:0]      req_script_byte,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [isc_pkg::BYTE_W-1:0]      rsp_cmd_byte,
   input  logic                            rsp_byte_valid,
   input  logic                            rsp_last_of_cmd,
   input  logic [1:0]                      rsp_status,
   input  logic                            csr_write_en,
   input  logic [isc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [isc_pkg::CSR_W-1:0]       csr_wdata
);
   import isc_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cmd_byte)
         && $stable(rsp_byte_valid) && $stable(rsp_last_of_cmd) && $stable(rsp_status))
      else $error("rsp changed while stalled");

   // a command byte that does not close its packet never ends the run
   a_mid_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid && !rsp_last_of_cmd |-> rsp_status == ST_RUNNING)
      else $error("run ended on a byte inside a packet");

   // an empty result is always a final report
   a_empty_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_status != ST_RUNNING && !rsp_last_of_cmd
         && rsp_cmd_byte == '0)
      else $error("empty result without final status");

   // nothing follows the final report
   a_quiet_after_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_status != ST_RUNNING |=> !rsp_valid)
      else $error("result after done or fail");

   logic unused_ok;
   assign unused_ok = ^{req_valid, req_ready, req_script_byte, csr_write_en, csr_index,
                        csr_wdata};

endmodule

bind init_script_command_patcher isc_checker u_isc_checker (.*);

`default_nettype wire

// ===== test/init_script_command_patcher_test.sv =====
// init_script_command_patcher_test: self-checking bench for the init-script patcher; random
// packet streams under changing register settings, with stalls on both channels
// depends on isc_pkg and init_script_command_patcher
`timescale 1ns / 1ps

module init_script_command_patcher_test;
   import isc_pkg::*;

   typedef struct {
      logic [BYTE_W-1:0] cmd_byte;
      logic              byte_valid;
      logic              last_of_cmd;
      logic [1:0]        status;
   } cmd_result_type;

   typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} payload_fill_type;
   typedef enum {END_DONE, END_MISMATCH, END_SIZE_AT_TYPE, END_BAD_TYPE} script_end_type;

   localparam int START_DB_BASIC = 12;
   localparam int START_DB_EDR   = 10;
   localparam int FLOOR_DB       = -35;
   localparam int STEP_DB        = 5;
   localparam int MAX_STEP_COUNT = 6;
   localparam int LEVEL_LIMIT    = 4;
   localparam int PHASES         = 10;
   localparam int PHASE_ITEMS    = 95;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 8;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [BYTE_W-1:0]    req_script_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [BYTE_W-1:0]    rsp_cmd_byte;
   logic                 rsp_byte_valid;
   logic                 rsp_last_of_cmd;
   logic [1:0]           rsp_status;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // register copies and parser state of the predictor
   logic signed [DB_W-1:0] max_db_cfg      = MAX_POWER_RESET;
   logic                   sleep_cfg       = 1'b0;
   logic [COUNT_W-1:0]     script_size_cfg = SCRIPT_SIZE_RESET;
   logic [PKT_W-1:0]       packet_goal_cfg = EXP_PACKETS_RESET;
   logic [1:0]             parse_state     = PH_TYPE;
   logic [INDEX_W-1:0]     cmd_pos         = '0;
   logic [OPC_W-1:0]       opcode_seen     = '0;
   logic [BYTE_W-1:0]      length_seen     = '0;
   logic [BYTE_W-1:0]      mod_seen        = '0;
   logic [COUNT_W-1:0]     bytes_count     = '0;
   logic [PKT_W-1:0]       packets_count   = '0;
   logic [1:0]             run_state       = ST_RUNNING;

   cmd_result_type    expected_bytes[$];
   logic [BYTE_W-1:0] script_queue[$];

   int   error_count    = 0;
   int   accepted_count = 0;
   int   send_odds      = 0;
   int   recv_odds      = 0;
   int   send_gap       = 0;
   int   recv_gap       = 0;
   logic hold_rsp       = 1'b0;
   int   db_pick [8]    = '{-40, 20, 13, 12, 10, 11, 3, -35};
   int   odds_pick [4]  = '{0, 5, 15, 40};

   init_script_command_patcher dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int capped_start_db(input logic [BYTE_W-1:0] kind);
      int s;
      s = (kind == '0) ? START_DB_BASIC : START_DB_EDR;
      return (s > int'(max_db_cfg)) ? int'(max_db_cfg) : s;
   endfunction

   function automatic logic [BYTE_W-1:0] patched_value(input int idx,
                                                       input logic [BYTE_W-1:0] b);
      int p;
      int k;
      int lvl;
      if (opcode_seen == OPC_POWER_VECTOR) begin
         if (idx >= 5 && idx <= POWER_LEVELS + 3) begin
            k = POWER_LEVELS + 3 - idx;
            if (k > MAX_STEP_COUNT) k = MAX_STEP_COUNT;
            p = capped_start_db(mod_seen) - STEP_DB * k;
            // the top level is sent unclamped
            if (k != 0 && p < FLOOR_DB) p = FLOOR_DB;
            return BYTE_W'(2 * p);
         end
      end else if (opcode_seen == OPC_POWER_LEVEL) begin
         if (idx >= 3 && idx <= 5) begin
            p = capped_start_db(BYTE_W'(idx - 3));
            lvl = POWER_LEVELS - 1;
            while (lvl != 0 && p >= LEVEL_LIMIT) begin
               p -= STEP_DB;
               lvl--;
            end
            return BYTE_W'(lvl);
         end
      end else if (opcode_seen == OPC_SLEEP_CFG) begin
         if (idx == 4) return {7'd0, sleep_cfg};
      end
      return b;
   endfunction

   function automatic void close_script();
      run_state = (packets_count == packet_goal_cfg) ? ST_DONE : ST_MISMATCH;
      parse_state = PH_IDLE;
   endfunction

   function automatic void accept_byte(input logic [BYTE_W-1:0] b);
      cmd_result_type r;
      int             idx;
      logic           last;
      r.cmd_byte    = '0;
      r.byte_valid  = 1'b0;
      r.last_of_cmd = 1'b0;
      if (parse_state == PH_IDLE) return;
      if (parse_state == PH_TYPE) begin
         if (bytes_count >= script_size_cfg) begin
            close_script();
            r.status = run_state;
            expected_bytes.push_back(r);
         end else if (b != PKT_TYPE_CMD) begin
            run_state = ST_BAD_TYPE;
            parse_state = PH_IDLE;
            r.status = run_state;
            expected_bytes.push_back(r);
         end else begin
            if (bytes_count != BYTES_MAX) bytes_count++;
            cmd_pos = '0;
            parse_state = PH_BODY;
         end
         return;
      end
      idx = int'(cmd_pos);
      if (idx == 0) opcode_seen = {8'h00, b};
      else if (idx == 1) opcode_seen[15:8] = b;
      else if (idx == 2) length_seen = b;
      else if (idx == 3) mod_seen = b;
      last = (idx >= 2) && (idx == 2 + int'(length_seen));
      r.cmd_byte = (idx >= 3) ? patched_value(idx, b) : b;
      if (bytes_count != BYTES_MAX) bytes_count++;
      cmd_pos = cmd_pos + 1'b1;
      if (last) begin
         packets_count = packets_count + 1'b1;
         parse_state = PH_TYPE;
         if (bytes_count >= script_size_cfg) close_script();
      end
      r.byte_valid  = 1'b1;
      r.last_of_cmd = last;
      r.status      = run_state;
      expected_bytes.push_back(r);
   endfunction

   function automatic int push_packet(input logic [OPC_W-1:0] opcode, input int len,
                                      input payload_fill_type fill);
      logic [BYTE_W-1:0] v;
      script_queue.push_back(PKT_TYPE_CMD);
      script_queue.push_back(opcode[7:0]);
      script_queue.push_back(opcode[15:8]);
      script_queue.push_back(BYTE_W'(len));
      for (int i = 0; i < len; i++) begin
         case (fill)
            FILL_ZERO: v = 8'h00;
            FILL_ONES: v = 8'hFF;
            default: v = (i == 0 && $urandom_range(0, 1) == 1) ? 8'h00 : BYTE_W'($urandom);
         endcase
         script_queue.push_back(v);
      end
      return len + 4;
   endfunction

   function automatic int push_random_packet();
      int               pick;
      int               len;
      logic [OPC_W-1:0] opcode;
      pick = $urandom_range(0, 9);
      if (pick <= 2) opcode = OPC_POWER_VECTOR;
      else if (pick <= 4) opcode = OPC_POWER_LEVEL;
      else if (pick <= 6) opcode = OPC_SLEEP_CFG;
      else if (pick == 7) opcode = OPC_POWER_VECTOR ^ (16'd1 << $urandom_range(0, 15));
      else opcode = OPC_W'($urandom);
      if ($urandom_range(0, 39) == 0) len = $urandom_range(200, 255);
      else if (opcode == OPC_POWER_VECTOR && $urandom_range(0, 3) != 0)
         len = $urandom_range(15, 20);
      else len = $urandom_range(0, 8);
      return push_packet(opcode, len, FILL_RANDOM);
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (index)
         CSR_MAX_POWER:   max_db_cfg = value[DB_W-1:0];
         CSR_SLEEP_EN:    sleep_cfg = value[0];
         CSR_SCRIPT_SIZE: script_size_cfg = value[COUNT_W-1:0];
         CSR_EXP_PACKETS: packet_goal_cfg = value[PKT_W-1:0];
         default:         sleep_cfg = sleep_cfg;
      endcase
   endtask

   // all bytes transferred, all results seen, then a wait for bytes without a result
   task automatic settle();
      while (script_queue.size() != 0 || req_valid) @(negedge clock);
      while (expected_bytes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            accept_byte(req_script_byte);
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (script_queue.size() == 0) begin
               req_valid <= 1'b0;
            end else if ($urandom_range(1, 100) <= send_odds) begin
               send_gap = $urandom_range(0, 17);
               req_valid <= 1'b0;
            end else begin
               req_valid       <= 1'b1;
               req_script_byte <= script_queue.pop_front();
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      cmd_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected transfer: cmd_byte %0h byte_valid %0b last_of_cmd %0b status %0d",
                      rsp_cmd_byte, rsp_byte_valid, rsp_last_of_cmd, rsp_status);
               error_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_cmd_byte !== want.cmd_byte) begin
                  $error("cmd_byte: expected %0h, got %0h", want.cmd_byte, rsp_cmd_byte);
                  error_count++;
               end
               if (rsp_byte_valid !== want.byte_valid) begin
                  $error("byte_valid: expected %0b, got %0b", want.byte_valid, rsp_byte_valid);
                  error_count++;
               end
               if (rsp_last_of_cmd !== want.last_of_cmd) begin
                  $error("last_of_cmd: expected %0b, got %0b", want.last_of_cmd, rsp_last_of_cmd);
                  error_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  error_count++;
               end
            end
         end
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(1, 100) <= recv_odds) begin
            recv_gap = $urandom_range(0, 17);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // long receiver stall while bytes keep coming, so the input backs up
   initial begin
      while (accepted_count < 400) @(negedge clock);
      hold_rsp = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      int             pushed;
      int             db;
      int             len;
      script_end_type finish_how;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // short vector with modulation zero, level and sleep commands, empty payload
      void'(push_packet(OPC_POWER_VECTOR, 8, FILL_ZERO));
      void'(push_packet(OPC_POWER_LEVEL, 3, FILL_ONES));
      void'(push_packet(OPC_SLEEP_CFG, 2, FILL_ONES));
      void'(push_packet(16'hFFFF, 0, FILL_RANDOM));
      settle();

      for (int phase = 0; phase < PHASES; phase++) begin
         db = (phase < 8) ? db_pick[phase] : int'($urandom_range(0, 60)) - 40;
         write_reg(CSR_MAX_POWER, CSR_W'(db));
         write_reg(CSR_SLEEP_EN, CSR_W'((phase + 1) % 2));
         write_reg(CSR_EXP_PACKETS, phase == 0 ? CSR_W'(0) :
                   phase == 1 ? CSR_W'(16'hFFFF) : CSR_W'($urandom_range(0, 65535)));
         write_reg(CSR_SCRIPT_SIZE, phase == 0 ? CSR_W'(BYTES_MAX) :
                   CSR_W'($urandom_range(65536, 16777215)));
         if (phase == PHASES - 1) begin
            send_odds = 0;
            recv_odds = 0;
         end else begin
            send_odds = odds_pick[$urandom_range(0, 3)];
            recv_odds = odds_pick[$urandom_range(0, 3)];
         end
         @(negedge clock);
         pushed = 0;
         while (pushed < PHASE_ITEMS) pushed += push_random_packet();
         settle();
      end

      // end of script: one way of stopping, then bytes the idle block must ignore
      finish_how = script_end_type'($urandom_range(0, 3));
      case (finish_how)
         END_DONE, END_MISMATCH: begin
            len = $urandom_range(0, 20);
            write_reg(CSR_SCRIPT_SIZE, CSR_W'(int'(bytes_count) + $urandom_range(1, len + 4)));
            write_reg(CSR_EXP_PACKETS,
                      CSR_W'(int'(packets_count) + (finish_how == END_DONE ? 1 : 2)));
            @(negedge clock);
            void'(push_packet(OPC_POWER_VECTOR, len, FILL_RANDOM));
         end
         END_SIZE_AT_TYPE: begin
            write_reg(CSR_SCRIPT_SIZE, CSR_W'(1));
            write_reg(CSR_EXP_PACKETS, CSR_W'(int'(packets_count) + $urandom_range(0, 1)));
            @(negedge clock);
            script_queue.push_back(PKT_TYPE_CMD);
         end
         END_BAD_TYPE: begin
            @(negedge clock);
            script_queue.push_back($urandom_range(0, 1) == 1 ? 8'h00 :
                                   BYTE_W'($urandom_range(2, 255)));
         end
      endcase
      void'(push_random_packet());
      repeat (4) script_queue.push_back(BYTE_W'($urandom));
      settle();

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
